// ===== rtl/lcs_pkg.sv =====
// Shared opcodes, field widths and defaults for the LCS engine.
package lcs_pkg;

   localparam int OPC_W       = 2;
   localparam int SYM_W       = 8;
   localparam int LCS_W       = 6;
   localparam int DEF_MAX_LEN = 32;

   localparam logic [OPC_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OPC_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OPC_W-1:0] OP_RUN      = 2'd2;

endpackage

// ===== rtl/longest_common_subsequence.sv =====
// LCS engine: string load, score table fill, traceback and result emission.
//
//   channel | direction | fields
//   req_    | in        | opcode, symbol
//   rsp_    | out       | lcs_length, symbol_res, symbol_valid, overflow, last
//
// A run with lengths m and n fills the table one cell per cycle, then takes a read
// state and an evaluate state per traceback step (at most m+n steps), then a read
// state and a load state per result item. Reset is synchronous and leaves no
// clearing pass: strings, table and answer buffer are only read where the same
// load or run wrote them.
// A stalled rsp_ready holds the engine at its next result; req_ready is low during a run.
module longest_common_subsequence #(
   parameter int MAX_LEN = lcs_pkg::DEF_MAX_LEN
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lcs_pkg::OPC_W-1:0] req_opcode,
   input  logic [lcs_pkg::SYM_W-1:0] req_symbol,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lcs_pkg::LCS_W-1:0] rsp_lcs_length,
   output logic [lcs_pkg::SYM_W-1:0] rsp_symbol_res,
   output logic                      rsp_symbol_valid,
   output logic                      rsp_overflow,
   output logic                      rsp_last
);
   import lcs_pkg::*;

   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CELLS  = 2 ** ADDR_W;
   localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] ONE   = LEN_W'(1);
   localparam logic [LEN_W-1:0] ZERO  = '0;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FILL   = 3'd1;
   localparam logic [2:0] S_TB_RD  = 3'd2;
   localparam logic [2:0] S_TB_EV  = 3'd3;
   localparam logic [2:0] S_OUT_RD = 3'd4;
   localparam logic [2:0] S_OUT_LD = 3'd5;

   logic [SYM_W-1:0] first_mem  [MAX_LEN];
   logic [SYM_W-1:0] second_mem [MAX_LEN];
   logic [SYM_W-1:0] ans_mem    [MAX_LEN];
   logic [LEN_W-1:0] score_mem  [CELLS];

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len1_ff, len2_ff, m_ff, n_ff;
   logic              ovf_ff, run_ovf_ff;
   logic [LEN_W-1:0]  i_ff, j_ff, k_ff, ok_ff, len_ff;
   logic              iss_done_ff;
   logic              c_vld_ff, c_i1_ff, c_j1_ff, c_last_ff;
   logic [ADDR_W-1:0] c_waddr_ff;
   logic [LEN_W-1:0]  left_ff, diag_ff;
   logic              fwd_ff;
   logic [LEN_W-1:0]  fwd_val_ff;
   logic [SYM_W-1:0]  first_q, second_q, ans_q;
   logic [LEN_W-1:0]  sc_qa, sc_qb;
   logic              rsp_valid_ff, rsp_sv_ff, rsp_ovf_ff, rsp_last_ff;
   logic [LCS_W-1:0]  rsp_len_ff;
   logic [SYM_W-1:0]  rsp_sym_ff;

   logic              req_fire, run_start, issue, is_last_cell;
   logic [LEN_W-1:0]  im1, im2, jm1, jm2, km1;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic              first_rd_en, second_rd_en;
   logic [LEN_W-1:0]  up_c, left_c, diag_c, cell_val;
   logic [LEN_W-1:0]  tb_up, tb_left;
   logic              tb_match, tb_done, rsp_load, out_last;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign run_start = req_fire && (req_opcode == OP_RUN);
   assign issue     = (state_ff == S_FILL) && !iss_done_ff;
   assign is_last_cell = (i_ff == m_ff) && (j_ff == n_ff);

   assign im1 = i_ff - ONE;
   assign im2 = i_ff - LEN_W'(2);
   assign jm1 = j_ff - ONE;
   assign jm2 = j_ff - LEN_W'(2);
   assign km1 = k_ff - ONE;

   // port A: cell above the current one, port B: cell to its left (table rows/cols from 1)
   assign rd_a_addr = {im2[IDX_W-1:0], jm1[IDX_W-1:0]};
   assign rd_b_addr = {im1[IDX_W-1:0], jm2[IDX_W-1:0]};

   assign first_rd_en  = (issue && (j_ff == ONE)) || (state_ff == S_TB_RD);
   assign second_rd_en = issue || (state_ff == S_TB_RD);

   // fill compute stage; row 0 and column 0 are implicit zeros
   assign up_c   = c_i1_ff ? ZERO : (fwd_ff ? fwd_val_ff : sc_qa);
   assign left_c = c_j1_ff ? ZERO : left_ff;
   assign diag_c = c_j1_ff ? ZERO : diag_ff;
   assign cell_val = (first_q == second_q) ? LEN_W'(diag_c + ONE)
                                           : ((up_c > left_c) ? up_c : left_c);

   assign tb_match = (first_q == second_q);
   assign tb_up    = (i_ff == ONE) ? ZERO : sc_qa;
   assign tb_left  = (j_ff == ONE) ? ZERO : sc_qb;
   assign tb_done  = (i_ff == ZERO) || (j_ff == ZERO);

   assign rsp_load = (state_ff == S_OUT_LD) && (!rsp_valid_ff || rsp_ready);
   assign out_last = (len_ff == ZERO) || (LEN_W'(ok_ff + ONE) == len_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (run_start) begin
               state_in = ((len1_ff == ZERO) || (len2_ff == ZERO)) ? S_OUT_LD : S_FILL;
            end
         end
         S_FILL: begin
            if (c_vld_ff && c_last_ff) state_in = S_TB_RD;
         end
         S_TB_RD: begin
            if (tb_done) state_in = (len_ff == ZERO) ? S_OUT_LD : S_OUT_RD;
            else         state_in = S_TB_EV;
         end
         S_TB_EV:  state_in = S_TB_RD;
         S_OUT_RD: state_in = S_OUT_LD;
         S_OUT_LD: begin
            if (rsp_load) state_in = out_last ? S_IDLE : S_OUT_RD;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len1_ff      <= '0;
         len2_ff      <= '0;
         ovf_ff       <= 1'b0;
         iss_done_ff  <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         c_vld_ff <= issue;
         if (req_fire) begin
            case (req_opcode)
               OP_APPEND_A: begin
                  if (len1_ff < MAX_L) len1_ff <= len1_ff + ONE;
                  else                 ovf_ff  <= 1'b1;
               end
               OP_APPEND_B: begin
                  if (len2_ff < MAX_L) len2_ff <= len2_ff + ONE;
                  else                 ovf_ff  <= 1'b1;
               end
               OP_RUN: begin
                  len1_ff     <= '0;
                  len2_ff     <= '0;
                  ovf_ff      <= 1'b0;
                  iss_done_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (issue && is_last_cell) iss_done_ff <= 1'b1;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (run_start) begin
         m_ff       <= len1_ff;
         n_ff       <= len2_ff;
         run_ovf_ff <= ovf_ff;
         i_ff       <= ONE;
         j_ff       <= ONE;
         len_ff     <= '0;
         ok_ff      <= '0;
      end
      if (issue) begin
         c_i1_ff    <= (i_ff == ONE);
         c_j1_ff    <= (j_ff == ONE);
         c_last_ff  <= is_last_cell;
         c_waddr_ff <= {im1[IDX_W-1:0], jm1[IDX_W-1:0]};
         // cell written this cycle is the one about to be read (single-column table)
         fwd_ff     <= c_vld_ff && (rd_a_addr == c_waddr_ff);
         fwd_val_ff <= cell_val;
         if (!is_last_cell) begin
            if (j_ff == n_ff) begin
               j_ff <= ONE;
               i_ff <= i_ff + ONE;
            end else begin
               j_ff <= j_ff + ONE;
            end
         end
      end
      if (c_vld_ff) begin
         left_ff <= cell_val;
         diag_ff <= up_c;
         if (c_last_ff) begin
            len_ff <= cell_val;
            k_ff   <= cell_val;
            i_ff   <= m_ff;
            j_ff   <= n_ff;
         end
      end
      if (state_ff == S_TB_EV) begin
         if (tb_match) begin
            if (k_ff != ZERO) k_ff <= km1;
            i_ff <= im1;
            j_ff <= jm1;
         end else if (tb_up > tb_left) begin
            i_ff <= im1;
         end else begin
            j_ff <= jm1;
         end
      end
      if (rsp_load) begin
         rsp_len_ff  <= LCS_W'(len_ff);
         rsp_sym_ff  <= (len_ff == ZERO) ? '0 : ans_q;
         rsp_sv_ff   <= (len_ff != ZERO);
         rsp_ovf_ff  <= run_ovf_ff;
         rsp_last_ff <= out_last;
         ok_ff       <= ok_ff + ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_opcode == OP_APPEND_A) && (len1_ff < MAX_L)) begin
         first_mem[len1_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (first_rd_en) first_q <= first_mem[im1[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_opcode == OP_APPEND_B) && (len2_ff < MAX_L)) begin
         second_mem[len2_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (second_rd_en) second_q <= second_mem[jm1[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (c_vld_ff) score_mem[c_waddr_ff] <= cell_val;
      if (issue || (state_ff == S_TB_RD)) sc_qa <= score_mem[rd_a_addr];
      if (state_ff == S_TB_RD) sc_qb <= score_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_TB_EV) && tb_match && (k_ff != ZERO)) begin
         ans_mem[km1[IDX_W-1:0]] <= first_q;
      end
      if (state_ff == S_OUT_RD) ans_q <= ans_mem[ok_ff[IDX_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lcs_length   = rsp_len_ff;
   assign rsp_symbol_res   = rsp_sym_ff;
   assign rsp_symbol_valid = rsp_sv_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_last         = rsp_last_ff;

   a_cvld_in_fill: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> (state_ff == S_FILL))
      else $error("fill compute stage active outside fill");

   a_fill_end: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && c_last_ff) |=> ((state_ff == S_TB_RD) && (len_ff <= m_ff)
                                   && (len_ff <= n_ff)))
      else $error("score exceeds string length at end of fill");

   a_tb_bounds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_TB_RD) || (state_ff == S_TB_EV))
         |-> ((i_ff <= m_ff) && (j_ff <= n_ff) && (k_ff <= len_ff)))
      else $error("traceback index out of range");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      run_start |=> !req_ready)
      else $error("run did not block new items");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && out_last) |=> (state_ff == S_IDLE))
      else $error("engine busy after final result");

endmodule

// ===== sim/tb.sv =====
// Testbench for the LCS engine: string loads, runs and per-item result checks.
module tb;
   import lcs_pkg::*;

   localparam int                MAX_LEN        = DEF_MAX_LEN;
   localparam logic [OPC_W-1:0]  OP_UNUSED      = 2'd3;
   localparam int                WATCHDOG_LIMIT = 20000;
   localparam int                HOLD_CYCLES    = 400;
   localparam int                DRAIN_CYCLES   = 100;
   localparam int                REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [LCS_W-1:0] length;
      logic [SYM_W-1:0] sym;
      logic             sym_valid;
      logic             overflow;
      logic             last;
   } lcs_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [OPC_W-1:0]  req_opcode;
   logic [SYM_W-1:0]  req_symbol;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [LCS_W-1:0]  rsp_lcs_length;
   logic [SYM_W-1:0]  rsp_symbol_res;
   logic              rsp_symbol_valid;
   logic              rsp_overflow;
   logic              rsp_last;

   longest_common_subsequence #(.MAX_LEN(MAX_LEN)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lcs_length  (rsp_lcs_length),
      .rsp_symbol_res  (rsp_symbol_res),
      .rsp_symbol_valid(rsp_symbol_valid),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   // predictor state
   logic [SYM_W-1:0] str_a [MAX_LEN];
   logic [SYM_W-1:0] str_b [MAX_LEN];
   int               len_a    = 0;
   int               len_b    = 0;
   logic             cut_seen = 1'b0;
   logic [LCS_W-1:0] score [0:MAX_LEN][0:MAX_LEN];
   lcs_result_type   awaited_results [$];

   int send_idle_pct = 35;
   int recv_idle_pct = 63;
   bit hold_request  = 1'b0;
   int items_sent    = 0;
   int fail_count    = 0;
   int report_count  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (report_count < REPORT_LIMIT) begin
         $display("ERROR: %s", msg);
         report_count++;
      end
   endfunction

   function automatic string show(input lcs_result_type r);
      return $sformatf("len=%0d sym=%02h sv=%b ovf=%b last=%b",
                       r.length, r.sym, r.sym_valid, r.overflow, r.last);
   endfunction

   // Fill the score table, trace back (ties go left) and queue the items of one run.
   function automatic void solve_subsequence();
      int               i, j, k, total;
      logic [SYM_W-1:0] picked [MAX_LEN];
      lcs_result_type   r;
      for (i = 0; i <= len_a; i++) score[i][0] = '0;
      for (j = 0; j <= len_b; j++) score[0][j] = '0;
      for (i = 1; i <= len_a; i++) begin
         for (j = 1; j <= len_b; j++) begin
            if (str_a[i-1] == str_b[j-1])
               score[i][j] = score[i-1][j-1] + 1'b1;
            else if (score[i-1][j] > score[i][j-1])
               score[i][j] = score[i-1][j];
            else
               score[i][j] = score[i][j-1];
         end
      end
      total = int'(score[len_a][len_b]);
      k = total;
      i = len_a;
      j = len_b;
      while (i > 0 && j > 0) begin
         if (str_a[i-1] == str_b[j-1]) begin
            if (k > 0) begin
               picked[k-1] = str_a[i-1];
               k--;
            end
            i--;
            j--;
         end else if (score[i-1][j] > score[i][j-1]) begin
            i--;
         end else begin
            j--;
         end
      end
      if (total == 0) begin
         r = '{length: '0, sym: '0, sym_valid: 1'b0, overflow: cut_seen, last: 1'b1};
         awaited_results.push_back(r);
      end else begin
         for (k = 0; k < total; k++) begin
            r = '{length: LCS_W'(total), sym: picked[k], sym_valid: 1'b1,
                  overflow: cut_seen, last: (k + 1 == total)};
            awaited_results.push_back(r);
         end
      end
      len_a    = 0;
      len_b    = 0;
      cut_seen = 1'b0;
   endfunction

   function automatic void track_item(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym);
      case (op)
         OP_APPEND_A: begin
            if (len_a < MAX_LEN) begin
               str_a[len_a] = sym;
               len_a++;
            end else begin
               cut_seen = 1'b1;
            end
         end
         OP_APPEND_B: begin
            if (len_b < MAX_LEN) begin
               str_b[len_b] = sym;
               len_b++;
            end else begin
               cut_seen = 1'b1;
            end
         end
         OP_RUN: solve_subsequence();
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      track_item(op, sym);
      if (op != OP_UNUSED) items_sent++;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol(input logic narrow,
                                                    input logic [SYM_W-1:0] base);
      // a narrow alphabet gives long common subsequences
      if (narrow) return SYM_W'(base + $urandom_range(3));
      return SYM_W'($urandom_range(255));
   endfunction

   // receiver: random backpressure, or a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      lcs_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{length: rsp_lcs_length, sym: rsp_symbol_res, sym_valid: rsp_symbol_valid,
                 overflow: rsp_overflow, last: rsp_last};
         if (awaited_results.size() == 0) begin
            note_failure($sformatf("unexpected item: %s", show(got)));
         end else begin
            want = awaited_results.pop_front();
            if (got !== want)
               note_failure($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   task automatic test_empty_runs();
      send_item(OP_RUN, 8'hff);
      send_item(OP_APPEND_A, 8'h55);
      send_item(OP_RUN, 8'h00);
      send_item(OP_APPEND_B, 8'haa);
      send_item(OP_RUN, 8'h5a);
   endtask

   task automatic test_unused_opcode();
      // an ignored opcode must not append to either string
      send_item(OP_APPEND_A, 8'h12);
      send_item(OP_UNUSED, 8'h12);
      send_item(OP_UNUSED, 8'hff);
      send_item(OP_RUN, 8'h00);
   endtask

   task automatic test_symbol_extremes();
      // crossed pair: tie at the corner moves left
      send_item(OP_APPEND_A, 8'h00);
      send_item(OP_APPEND_A, 8'hff);
      send_item(OP_APPEND_B, 8'hff);
      send_item(OP_APPEND_B, 8'h00);
      send_item(OP_RUN, 8'h00);
      send_item(OP_APPEND_A, 8'h00);
      send_item(OP_APPEND_B, 8'h00);
      send_item(OP_APPEND_A, 8'hff);
      send_item(OP_APPEND_B, 8'hff);
      send_item(OP_APPEND_A, 8'h80);
      send_item(OP_APPEND_B, 8'h80);
      send_item(OP_RUN, 8'hff);
   endtask

   task automatic test_full_strings();
      logic [SYM_W-1:0] text [MAX_LEN];
      logic [SYM_W-1:0] base;
      base = SYM_W'($urandom_range(255));
      foreach (text[i]) text[i] = pick_symbol(1'b1, base);
      foreach (text[i]) send_item(OP_APPEND_A, text[i]);
      foreach (text[i]) send_item(OP_APPEND_B, text[i]);
      send_item(OP_RUN, SYM_W'($urandom_range(255)));
   endtask

   task automatic test_overflow();
      logic [SYM_W-1:0] base;
      logic [SYM_W-1:0] sym;
      base = SYM_W'($urandom_range(255));
      repeat (MAX_LEN + 2) send_item(OP_APPEND_A, pick_symbol(1'b1, base));
      repeat (MAX_LEN + 1) send_item(OP_APPEND_B, pick_symbol(1'b1, base));
      send_item(OP_RUN, SYM_W'($urandom_range(255)));
      // the flag must be gone on the next run
      sym = SYM_W'($urandom_range(255));
      send_item(OP_APPEND_A, sym);
      send_item(OP_APPEND_B, sym);
      send_item(OP_RUN, SYM_W'($urandom_range(255)));
   endtask

   task automatic test_receiver_stall();
      hold_request = 1'b1;
      repeat (4) send_item(OP_APPEND_A, pick_symbol(1'b1, 8'h40));
      repeat (4) send_item(OP_APPEND_B, pick_symbol(1'b1, 8'h40));
      send_item(OP_RUN, 8'h00);
      // these wait behind the stalled run
      repeat (3) send_item(OP_APPEND_A, pick_symbol(1'b1, 8'h40));
      repeat (3) send_item(OP_APPEND_B, pick_symbol(1'b1, 8'h40));
      send_item(OP_RUN, 8'h00);
   endtask

   task automatic random_sequence();
      int               kind, m, n, ia, ib;
      logic             narrow;
      logic [SYM_W-1:0] base;
      kind   = $urandom_range(99);
      narrow = ($urandom_range(9) < 7);
      base   = SYM_W'($urandom_range(255));
      if (kind < 8) begin
         // noise: any opcode, any order
         repeat ($urandom_range(6, 1))
            send_item(OPC_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
      end else begin
         if (kind < 14) begin
            m = $urandom_range(MAX_LEN + 4, MAX_LEN - 4);
            n = $urandom_range(MAX_LEN + 4, MAX_LEN - 4);
         end else begin
            m = $urandom_range(8);
            n = $urandom_range(8);
         end
         ia = 0;
         ib = 0;
         while (ia < m || ib < n) begin
            if ($urandom_range(19) == 0) begin
               send_item(OP_UNUSED, SYM_W'($urandom_range(255)));
            end else if (ib >= n || (ia < m && $urandom_range(1))) begin
               send_item(OP_APPEND_A, pick_symbol(narrow, base));
               ia++;
            end else begin
               send_item(OP_APPEND_B, pick_symbol(narrow, base));
               ib++;
            end
         end
         send_item(OP_RUN, SYM_W'($urandom_range(255)));
      end
   endtask

   task automatic test_random_traffic(input int goal);
      int start;
      start = items_sent;
      while (items_sent - start < goal) random_sequence();
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = OP_APPEND_A;
      req_symbol = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_runs();
      test_unused_opcode();
      test_symbol_extremes();
      test_full_strings();
      test_overflow();
      test_random_traffic(60);

      send_idle_pct = 63;
      recv_idle_pct = 35;
      test_random_traffic(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_stall();
      test_random_traffic(60);

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
